// File: rtl/vn_pkg.sv
// vector normalize package: widths, stage counts and side-band structs
// shared by the interfaces and every module of the vector3_normalize block
// depends on nothing
package vn_pkg;

  localparam int COMPONENT_WIDTH    = 16;
  localparam int UNIT_FRACTION_BITS = 14;

  localparam int LANES  = 3;
  localparam int OUT_W  = 16;
  localparam int EPS_W  = 16;

  // magnitude of a component fits its own width (most negative value included)
  localparam int MAG_W  = COMPONENT_WIDTH;
  localparam int SQ_W   = 2 * COMPONENT_WIDTH - 1;
  localparam int SUM_W  = 2 * COMPONENT_WIDTH;
  localparam int ROOT_W = COMPONENT_WIDTH;
  localparam int RREM_W = ROOT_W + 2;
  localparam int DREM_W = ROOT_W + 1;
  localparam int QUO_W  = UNIT_FRACTION_BITS + 1;
  localparam int QX_W   = QUO_W + OUT_W;
  localparam int CMP_W  = (ROOT_W > EPS_W) ? ROOT_W : EPS_W;

  // travels with the sum of squares through the root pipeline
  typedef struct packed {
    logic                        vld;
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } vn_vtag_t;

  // travels beside the divider lanes
  typedef struct packed {
    logic              vld;
    logic              norm;
    logic [ROOT_W-1:0] len;
  } vn_dtag_t;

endpackage

// File: rtl/vn_in_if.sv
// input channel of the vector normalize block: one vector per beat
// depends on vn_pkg
interface vn_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [vn_pkg::COMPONENT_WIDTH-1:0] x_in;
  logic signed [vn_pkg::COMPONENT_WIDTH-1:0] y_in;
  logic signed [vn_pkg::COMPONENT_WIDTH-1:0] z_in;

  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

// File: rtl/vn_out_if.sv
// result channel of the vector normalize block: unit vector and length per beat
// depends on vn_pkg
interface vn_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [vn_pkg::OUT_W-1:0] x_unit;
  logic signed [vn_pkg::OUT_W-1:0] y_unit;
  logic signed [vn_pkg::OUT_W-1:0] z_unit;
  logic        [vn_pkg::OUT_W-1:0] vec_length;
  logic                           normalized;

  modport source (output valid, x_unit, y_unit, z_unit, vec_length, normalized,
                  input ready);
  modport sink   (input valid, x_unit, y_unit, z_unit, vec_length, normalized,
                  output ready);
endinterface

// File: rtl/vn_sq_lane.sv
// one component lane: sign split, magnitude and registered square
// depends on vn_pkg
module vn_sq_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [vn_pkg::MAG_W-1:0]  comp_i,
  output logic        [vn_pkg::MAG_W-1:0]  mag_r,
  output logic                             neg_r,
  output logic        [vn_pkg::SQ_W-1:0]   sq_r
);

  logic [vn_pkg::MAG_W-1:0]   comp_u;
  logic [vn_pkg::MAG_W-1:0]   mag_nxt;
  logic                       neg_nxt;
  logic [2*vn_pkg::MAG_W-1:0] prod;

  assign comp_u  = comp_i;
  assign neg_nxt = comp_u[vn_pkg::MAG_W-1];
  assign mag_nxt = neg_nxt ? (~comp_u + vn_pkg::MAG_W'(1)) : comp_u;
  assign prod    = mag_nxt * mag_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
      sq_r  <= prod[vn_pkg::SQ_W-1:0];
    end
  end

endmodule

// File: rtl/vn_sqrt_pipe.sv
// sum of squares then floor square root, one root bit per pipeline stage
// depends on vn_pkg
module vn_sqrt_pipe (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           en,
  input  vn_pkg::vn_vtag_t                               tag_i,
  input  logic [vn_pkg::LANES-1:0][vn_pkg::SQ_W-1:0]     sq_i,
  output vn_pkg::vn_vtag_t                               tag_o,
  output logic [vn_pkg::ROOT_W-1:0]                      root_o
);

  logic [vn_pkg::SUM_W-1:0] sum_nxt;
  logic [vn_pkg::SUM_W-1:0] sum_r;
  vn_pkg::vn_vtag_t         stag_r;

  logic [vn_pkg::SUM_W-1:0]  rad_r    [vn_pkg::ROOT_W];
  logic [vn_pkg::RREM_W-1:0] rem_r    [vn_pkg::ROOT_W];
  logic [vn_pkg::ROOT_W-1:0] root_r   [vn_pkg::ROOT_W];
  vn_pkg::vn_vtag_t          tag_r    [vn_pkg::ROOT_W];
  logic [vn_pkg::SUM_W-1:0]  rad_nxt  [vn_pkg::ROOT_W];
  logic [vn_pkg::RREM_W-1:0] rem_nxt  [vn_pkg::ROOT_W];
  logic [vn_pkg::ROOT_W-1:0] root_nxt [vn_pkg::ROOT_W];
  vn_pkg::vn_vtag_t          tag_nxt  [vn_pkg::ROOT_W];

  assign sum_nxt = vn_pkg::SUM_W'(sq_i[0]) + vn_pkg::SUM_W'(sq_i[1])
                 + vn_pkg::SUM_W'(sq_i[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stag_r <= '0;
    end else if (en) begin
      stag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  // each stage brings down two radicand bits and tries root*4+1
  always_comb begin
    logic [vn_pkg::SUM_W-1:0]  rad_p;
    logic [vn_pkg::RREM_W-1:0] rem_p;
    logic [vn_pkg::ROOT_W-1:0] root_p;
    logic [vn_pkg::RREM_W-1:0] shifted;
    logic [vn_pkg::RREM_W-1:0] trial;
    logic                      ge;
    for (int s = 0; s < vn_pkg::ROOT_W; s++) begin
      if (s == 0) begin
        rad_p      = sum_r;
        rem_p      = '0;
        root_p     = '0;
        tag_nxt[s] = stag_r;
      end else begin
        rad_p      = rad_r[s-1];
        rem_p      = rem_r[s-1];
        root_p     = root_r[s-1];
        tag_nxt[s] = tag_r[s-1];
      end
      shifted     = {rem_p[vn_pkg::RREM_W-3:0], rad_p[vn_pkg::SUM_W-1-2*s -: 2]};
      trial       = {root_p, 2'b01};
      ge          = (shifted >= trial);
      rem_nxt[s]  = ge ? (shifted - trial) : shifted;
      root_nxt[s] = {root_p[vn_pkg::ROOT_W-2:0], ge};
      rad_nxt[s]  = rad_p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < vn_pkg::ROOT_W; s++) begin
        tag_r[s] <= '0;
      end
    end else if (en) begin
      for (int s = 0; s < vn_pkg::ROOT_W; s++) begin
        tag_r[s] <= tag_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < vn_pkg::ROOT_W; s++) begin
        rad_r[s]  <= rad_nxt[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
      end
    end
  end

  assign tag_o  = tag_r[vn_pkg::ROOT_W-1];
  assign root_o = root_r[vn_pkg::ROOT_W-1];

endmodule

// File: rtl/vn_div_lane.sv
// one divider lane: magnitude / length, one quotient bit per stage
// depends on vn_pkg; magnitude never exceeds the length when normalizing
module vn_div_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic [vn_pkg::MAG_W-1:0]         mag_i,
  input  logic                             neg_i,
  input  logic [vn_pkg::ROOT_W-1:0]        len_i,
  output logic [vn_pkg::QUO_W-1:0]         quo_o,
  output logic                             neg_o
);

  logic [vn_pkg::ROOT_W-1:0] rem_r    [vn_pkg::QUO_W];
  logic [vn_pkg::QUO_W-1:0]  quo_r    [vn_pkg::QUO_W];
  logic [vn_pkg::ROOT_W-1:0] len_r    [vn_pkg::QUO_W];
  logic                      neg_r    [vn_pkg::QUO_W];
  logic [vn_pkg::ROOT_W-1:0] rem_nxt  [vn_pkg::QUO_W];
  logic [vn_pkg::QUO_W-1:0]  quo_nxt  [vn_pkg::QUO_W];
  logic [vn_pkg::ROOT_W-1:0] len_nxt  [vn_pkg::QUO_W];
  logic                      neg_nxt  [vn_pkg::QUO_W];

  // first stage yields the integer bit, later stages the fraction bits
  always_comb begin
    logic [vn_pkg::DREM_W-1:0] part;
    logic [vn_pkg::DREM_W-1:0] diff;
    logic [vn_pkg::QUO_W-1:0]  quo_p;
    logic                      ge;
    for (int k = 0; k < vn_pkg::QUO_W; k++) begin
      if (k == 0) begin
        part       = {1'b0, mag_i};
        len_nxt[k] = len_i;
        quo_p      = '0;
        neg_nxt[k] = neg_i;
      end else begin
        part       = {rem_r[k-1], 1'b0};
        len_nxt[k] = len_r[k-1];
        quo_p      = quo_r[k-1];
        neg_nxt[k] = neg_r[k-1];
      end
      diff       = part - {1'b0, len_nxt[k]};
      ge         = (part >= {1'b0, len_nxt[k]});
      rem_nxt[k] = ge ? diff[vn_pkg::ROOT_W-1:0] : part[vn_pkg::ROOT_W-1:0];
      quo_nxt[k] = {quo_p[vn_pkg::QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < vn_pkg::QUO_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        len_r[k] <= len_nxt[k];
        neg_r[k] <= neg_nxt[k];
      end
    end
  end

  assign quo_o = quo_r[vn_pkg::QUO_W-1];
  assign neg_o = neg_r[vn_pkg::QUO_W-1];

endmodule

// File: rtl/vn_out_stage.sv
// merge of the divider lanes into one result beat, output register and skid
// depends on vn_pkg and vn_out_if
module vn_out_stage (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic [vn_pkg::LANES-1:0][vn_pkg::QUO_W-1:0] quo_i,
  input  logic [vn_pkg::LANES-1:0]                    neg_i,
  input  vn_pkg::vn_dtag_t                            dtag_i,
  output logic                                        pipe_ready,
  vn_out_if.source                                    out_bus
);

  typedef struct packed {
    logic [vn_pkg::LANES-1:0][vn_pkg::OUT_W-1:0] unit;
    logic [vn_pkg::OUT_W-1:0]                    len;
    logic                                        norm;
  } vn_result_t;

  vn_result_t res;
  vn_result_t out_dat_r, out_dat_nxt;
  vn_result_t skid_dat_r, skid_dat_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       skid_vld_r, skid_vld_nxt;
  logic       take;
  logic       pop;

  always_comb begin
    logic [vn_pkg::QX_W-1:0]            qx;
    logic [vn_pkg::ROOT_W+vn_pkg::OUT_W-1:0] lx;
    for (int i = 0; i < vn_pkg::LANES; i++) begin
      qx = {{vn_pkg::OUT_W{1'b0}}, quo_i[i]};
      if (neg_i[i]) begin
        qx = ~qx + vn_pkg::QX_W'(1);
      end
      res.unit[i] = dtag_i.norm ? qx[vn_pkg::OUT_W-1:0] : '0;
    end
    lx       = {{vn_pkg::OUT_W{1'b0}}, dtag_i.len};
    res.len  = lx[vn_pkg::OUT_W-1:0];
    res.norm = dtag_i.norm;
  end

  assign pipe_ready = !skid_vld_r;
  assign take       = dtag_i.vld && pipe_ready;
  assign pop        = out_vld_r && out_bus.ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_dat_nxt  = out_dat_r;
    skid_vld_nxt = skid_vld_r;
    skid_dat_nxt = skid_dat_r;
    if (take) begin
      if (!out_vld_r || pop) begin
        out_vld_nxt = 1'b1;
        out_dat_nxt = res;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_dat_nxt = res;
      end
    end else if (pop) begin
      if (skid_vld_r) begin
        out_dat_nxt  = skid_dat_r;
        skid_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r  <= out_dat_nxt;
    skid_dat_r <= skid_dat_nxt;
  end

  assign out_bus.valid      = out_vld_r;
  assign out_bus.x_unit     = out_dat_r.unit[0];
  assign out_bus.y_unit     = out_dat_r.unit[1];
  assign out_bus.z_unit     = out_dat_r.unit[2];
  assign out_bus.vec_length = out_dat_r.len;
  assign out_bus.normalized = out_dat_r.norm;

  // skid only ever holds the beat behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a beat while output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    take && out_vld_r && !out_bus.ready |=> skid_vld_r)
    else $error("beat taken during output stall was not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && out_bus.ready |=> !skid_vld_r && out_vld_r)
    else $error("skid beat did not move to output register");

  a_zero_unless_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_dat_r.norm |->
      out_dat_r.unit[0] == '0 && out_dat_r.unit[1] == '0 && out_dat_r.unit[2] == '0)
    else $error("unit components nonzero on an unnormalized beat");

endmodule

// File: rtl/vector3_normalize.sv
// vector3_normalize: length and unit vector of a 3-component Q8.8 vector
// pipeline: square, sum, 16 root stages, 15 divider stages, output register
// throughput: one vector per cycle unless the skid register holds a beat; the root and
// divider pipelines then stall, and otherwise take a new beat every cycle; the skid
// register keeps in_bus.ready off the out_bus.ready path
// reset: synchronous active-low rst_n clears all valid bits and eps_r to 0
module vector3_normalize (
  input  logic                      clk,
  input  logic                      rst_n,
  vn_in_if.sink                     in_bus,
  vn_out_if.source                  out_bus,
  input  logic                      cfg_we,
  input  logic [vn_pkg::EPS_W-1:0]  cfg_wdata
);

  logic                                          en;
  logic [vn_pkg::EPS_W-1:0]                      eps_r;
  logic                                          vld_a_r;
  logic [vn_pkg::LANES-1:0][vn_pkg::MAG_W-1:0]   comp_in;
  logic [vn_pkg::LANES-1:0][vn_pkg::MAG_W-1:0]   mag_a;
  logic [vn_pkg::LANES-1:0]                      neg_a;
  logic [vn_pkg::LANES-1:0][vn_pkg::SQ_W-1:0]    sq_a;
  vn_pkg::vn_vtag_t                              vtag_a;
  vn_pkg::vn_vtag_t                              tag_s;
  logic [vn_pkg::ROOT_W-1:0]                     root_s;
  logic                                          norm_s;
  vn_pkg::vn_dtag_t                              dtag_s;
  vn_pkg::vn_dtag_t                              dtag_r [vn_pkg::QUO_W];
  logic [vn_pkg::LANES-1:0][vn_pkg::QUO_W-1:0]   quo_d;
  logic [vn_pkg::LANES-1:0]                      neg_d;

  assign in_bus.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (cfg_we) begin
      eps_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_bus.valid;
    end
  end

  assign comp_in[0] = in_bus.x_in;
  assign comp_in[1] = in_bus.y_in;
  assign comp_in[2] = in_bus.z_in;

  for (genvar i = 0; i < vn_pkg::LANES; i++) begin : g_sq
    vn_sq_lane u_sq (
      .clk    (clk),
      .en     (en),
      .comp_i (comp_in[i]),
      .mag_r  (mag_a[i]),
      .neg_r  (neg_a[i]),
      .sq_r   (sq_a[i])
    );
  end

  always_comb begin
    vtag_a.vld = vld_a_r;
    vtag_a.neg = neg_a;
    vtag_a.mag = mag_a;
  end

  vn_sqrt_pipe u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tag_i  (vtag_a),
    .sq_i   (sq_a),
    .tag_o  (tag_s),
    .root_o (root_s)
  );

  // strictly greater: a length equal to the threshold is not normalized
  assign norm_s = vn_pkg::CMP_W'(root_s) > vn_pkg::CMP_W'(eps_r);

  always_comb begin
    dtag_s.vld  = tag_s.vld;
    dtag_s.norm = norm_s;
    dtag_s.len  = root_s;
  end

  for (genvar i = 0; i < vn_pkg::LANES; i++) begin : g_div
    vn_div_lane u_div (
      .clk   (clk),
      .en    (en),
      .mag_i (tag_s.mag[i]),
      .neg_i (tag_s.neg[i]),
      .len_i (root_s),
      .quo_o (quo_d[i]),
      .neg_o (neg_d[i])
    );
  end

  // side-band shift line that keeps pace with the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < vn_pkg::QUO_W; k++) begin
        dtag_r[k] <= '0;
      end
    end else if (en) begin
      dtag_r[0] <= dtag_s;
      for (int k = 1; k < vn_pkg::QUO_W; k++) begin
        dtag_r[k] <= dtag_r[k-1];
      end
    end
  end

  vn_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .quo_i      (quo_d),
    .neg_i      (neg_d),
    .dtag_i     (dtag_r[vn_pkg::QUO_W-1]),
    .pipe_ready (en),
    .out_bus    (out_bus)
  );

endmodule
